### rtl/gyro_yaw_differential_drive_correction_macros.svh
// assertion macros for the gyro yaw correction rtl
`ifndef GYRO_YAW_DIFFERENTIAL_DRIVE_CORRECTION_MACROS_SVH
`define GYRO_YAW_DIFFERENTIAL_DRIVE_CORRECTION_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GYDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gydc assertion failed");

// next-cycle implication
`define GYDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gydc assertion failed");

`else

`define GYDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GYDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/gydc_pkg.sv
// types and constants of the gyro yaw correction block
`timescale 1ns / 1ps
`default_nettype none

package gydc_pkg;

    localparam int ACC_W   = 40;   // yaw accumulator width
    localparam int DEV_W   = 40;   // reported deviation width
    localparam int GZ_W    = 16;
    localparam int MS_W    = 16;
    localparam int RS_W    = 2;
    localparam int PWM_W   = 8;
    localparam int DB_W    = 16;
    localparam int THR_W   = 39;
    localparam int PROD_W  = GZ_W + MS_W + 1;
    localparam int SCL_W   = ACC_W + PWM_W;
    localparam int CMP_W   = (ACC_W > THR_W) ? ACC_W : THR_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THR_W;

    // 65.5 lsb per deg/s times 1000 ms/s
    localparam int UNITS_PER_DEG = 65500;
    localparam int UPD_W  = 16;
    // quotient below the limit keeps the scaled value below (limit+1)*65500
    localparam int DIV_W  = PWM_W + UPD_W;
    localparam int CAP_W  = PWM_W + 1 + UPD_W;
    localparam int Q_W    = PWM_W + 1;
    localparam int RECIP_SH = 40;
    localparam int RECIP_W  = 25;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SH) / UNITS_PER_DEG);
    localparam int SPD_W  = PWM_W + 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH  = 3'd6;

    localparam logic [DB_W-1:0]  RST_DEADBAND  = 16'd328;
    localparam logic [THR_W-1:0] RST_THRESHOLD = 39'd196500;
    localparam logic [PWM_W-1:0] RST_GAIN      = 8'd10;
    localparam logic [PWM_W-1:0] RST_LIMIT     = 8'd50;
    localparam logic [PWM_W-1:0] RST_CLIMB     = 8'd180;
    localparam logic [PWM_W-1:0] RST_NORMAL    = 8'd150;
    localparam logic [PWM_W-1:0] RST_APPROACH  = 8'd120;

    // robot state codes
    localparam logic [RS_W-1:0] RS_NORMAL   = 2'd1;
    localparam logic [RS_W-1:0] RS_APPROACH = 2'd2;

    // input modes
    localparam logic MODE_CLEAR  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic [DB_W-1:0]  deadband;
        logic [THR_W-1:0] threshold;
        logic [PWM_W-1:0] gain;
        logic [PWM_W-1:0] limit;
        logic [PWM_W-1:0] climb;
        logic [PWM_W-1:0] normal;
        logic [PWM_W-1:0] approach;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mult;
        logic accum;
        logic scale;
        logic recip;
        logic quot;
        logic fix;
    } t_dp_cmd;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MULT  = 7'b0000010,
        S_ACCUM = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_RECIP = 7'b0010000,
        S_QUOT  = 7'b0100000,
        S_FIX   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

### rtl/gydc_if.sv
// input and result channels of the gyro yaw correction block
`timescale 1ns / 1ps
`default_nettype none

interface gydc_in_if import gydc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic signed [GZ_W-1:0] gyro_z;
    logic [MS_W-1:0]        elapsed_ms;
    logic [RS_W-1:0]        robot_state;

    modport source (output valid, mode, gyro_z, elapsed_ms, robot_state, input ready);
    modport sink   (input valid, mode, gyro_z, elapsed_ms, robot_state, output ready);
endinterface

interface gydc_out_if import gydc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    correcting;
    logic [PWM_W-1:0]        left_speed;
    logic [PWM_W-1:0]        right_speed;
    logic signed [DEV_W-1:0] deviation;

    modport source (output valid, correcting, left_speed, right_speed, deviation,
                    input ready);
    modport sink   (input valid, correcting, left_speed, right_speed, deviation,
                    output ready);
endinterface

`default_nettype wire

### rtl/gydc_cfg.sv
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module gydc_cfg import gydc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband  <= RST_DEADBAND;
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.gain      <= RST_GAIN;
            r_cfg.limit     <= RST_LIMIT;
            r_cfg.climb     <= RST_CLIMB;
            r_cfg.normal    <= RST_NORMAL;
            r_cfg.approach  <= RST_APPROACH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEADBAND:  r_cfg.deadband  <= i_cfg_data[DB_W-1:0];
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[THR_W-1:0];
                REG_GAIN:      r_cfg.gain      <= i_cfg_data[PWM_W-1:0];
                REG_LIMIT:     r_cfg.limit     <= i_cfg_data[PWM_W-1:0];
                REG_CLIMB:     r_cfg.climb     <= i_cfg_data[PWM_W-1:0];
                REG_NORMAL:    r_cfg.normal    <= i_cfg_data[PWM_W-1:0];
                REG_APPROACH:  r_cfg.approach  <= i_cfg_data[PWM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/gydc_dp.sv
// datapath: yaw integration, proportional correction and wheel speeds
`timescale 1ns / 1ps
`default_nettype none

module gydc_dp import gydc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_mode,
    input  wire logic signed [GZ_W-1:0]  i_gyro_z,
    input  wire logic [MS_W-1:0]         i_elapsed_ms,
    input  wire logic [RS_W-1:0]         i_robot_state,
    output logic                         o_correcting,
    output logic [PWM_W-1:0]             o_left_speed,
    output logic [PWM_W-1:0]             o_right_speed,
    output logic signed [DEV_W-1:0]      o_deviation
);

    // captured word
    logic                    r_mode;
    logic signed [GZ_W-1:0]  r_gz;
    logic [MS_W-1:0]         r_ms;
    logic                    r_rate_ok;
    logic [PWM_W-1:0]        r_base;

    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic [SCL_W-1:0]         r_scaled;
    logic                     r_corr_en;
    logic                     r_neg;
    logic                     r_big;
    logic [DIV_W-1:0]         r_num;
    logic [Q_W-1:0]           r_q0;
    logic [PWM_W-1:0]         r_cmag;

    logic                     r_o_corr;
    logic [PWM_W-1:0]         r_o_left;
    logic [PWM_W-1:0]         r_o_right;
    logic [DEV_W-1:0]         r_o_dev;

    logic [GZ_W:0]            gz_ext;
    logic [GZ_W:0]            gz_abs;
    logic                     rate_ok;
    logic [PWM_W-1:0]         base_sel;
    logic [ACC_W:0]           acc_sum;
    logic [ACC_W-1:0]         n_acc;
    logic [ACC_W-1:0]         acc_mag;
    logic                     over_thr;
    logic [PWM_W:0]           lim_p1;
    logic [CAP_W-1:0]         cap;
    logic [DIV_W+RECIP_W-1:0] q_prod;
    logic [Q_W+UPD_W-1:0]     q_back;
    logic [Q_W+UPD_W-1:0]     rem;
    logic [Q_W-1:0]           quo;
    logic [PWM_W-1:0]         n_cmag;
    logic [SPD_W-1:0]         base_x;
    logic [SPD_W-1:0]         cmag_x;
    logic [SPD_W-1:0]         lsum;
    logic [SPD_W-1:0]         rsum;
    logic [ACC_W-DEV_W:0]     acc_top;
    logic [DEV_W-1:0]         n_dev;

    function automatic logic [PWM_W-1:0] clamp_pwm(input logic [SPD_W-1:0] v);
        logic [PWM_W-1:0] res;
        if (v[SPD_W-1])
            res = '0;
        else if (|v[SPD_W-2:PWM_W])
            res = '1;
        else
            res = v[PWM_W-1:0];
        return res;
    endfunction

    always_comb begin
        gz_ext   = {i_gyro_z[GZ_W-1], i_gyro_z};
        gz_abs   = i_gyro_z[GZ_W-1] ? (~gz_ext + 1'b1) : gz_ext;
        rate_ok  = gz_abs >= {{(GZ_W+1-DB_W){1'b0}}, i_cfg.deadband};
        case (i_robot_state)
            RS_NORMAL:   base_sel = i_cfg.normal;
            RS_APPROACH: base_sel = i_cfg.approach;
            default:     base_sel = i_cfg.climb;
        endcase

        // saturating add of rate times time
        acc_sum = {r_acc[ACC_W-1], r_acc}
                + {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            n_acc = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                   : {1'b0, {(ACC_W-1){1'b1}}};
        else
            n_acc = acc_sum[ACC_W-1:0];

        acc_mag  = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
        over_thr = {{(CMP_W-ACC_W){1'b0}}, acc_mag}
                >= {{(CMP_W-THR_W){1'b0}}, i_cfg.threshold};

        // scaled magnitude at or above (limit+1)*65500 means clamp
        lim_p1 = {1'b0, i_cfg.limit} + 1'b1;
        cap    = {{UPD_W{1'b0}}, lim_p1} * CAP_W'(UNITS_PER_DEG);
        q_prod = {{RECIP_W{1'b0}}, r_scaled[DIV_W-1:0]}
               * {{DIV_W{1'b0}}, RECIP};

        // reciprocal estimate is low by at most one
        q_back = {{UPD_W{1'b0}}, r_q0} * (Q_W+UPD_W)'(UNITS_PER_DEG);
        rem    = {{(Q_W+UPD_W-DIV_W){1'b0}}, r_num} - q_back;
        quo    = (rem >= (Q_W+UPD_W)'(UNITS_PER_DEG)) ? (r_q0 + 1'b1) : r_q0;
        if (!r_corr_en)
            n_cmag = '0;
        else if (r_big || quo > {1'b0, i_cfg.limit})
            n_cmag = i_cfg.limit;
        else
            n_cmag = quo[PWM_W-1:0];

        base_x = {2'b00, r_base};
        cmag_x = {2'b00, r_cmag};
        lsum   = r_neg ? (base_x - cmag_x) : (base_x + cmag_x);
        rsum   = r_neg ? (base_x + cmag_x) : (base_x - cmag_x);

        acc_top = r_acc[ACC_W-1:DEV_W-1];
        if ((&acc_top) || !(|acc_top))
            n_dev = r_acc[DEV_W-1:0];
        else
            n_dev = r_acc[ACC_W-1] ? {1'b1, {(DEV_W-1){1'b0}}}
                                   : {1'b0, {(DEV_W-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            if (r_mode == MODE_CLEAR)
                r_acc <= '0;
            else if (r_rate_ok)
                r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_gz      <= i_gyro_z;
            r_ms      <= i_elapsed_ms;
            r_rate_ok <= rate_ok;
            r_base    <= base_sel;
        end
        if (i_cmd.mult)
            r_prod <= $signed({{(PROD_W-GZ_W){r_gz[GZ_W-1]}}, r_gz})
                    * $signed({{(PROD_W-MS_W){1'b0}}, r_ms});
        if (i_cmd.scale) begin
            r_scaled  <= {{PWM_W{1'b0}}, acc_mag} * {{ACC_W{1'b0}}, i_cfg.gain};
            r_corr_en <= (r_mode == MODE_SAMPLE) && over_thr;
            r_neg     <= r_acc[ACC_W-1];
        end
        if (i_cmd.recip) begin
            r_big <= r_scaled >= {{(SCL_W-CAP_W){1'b0}}, cap};
            r_num <= r_scaled[DIV_W-1:0];
            r_q0  <= q_prod[RECIP_SH +: Q_W];
        end
        if (i_cmd.quot)
            r_cmag <= n_cmag;
        if (i_cmd.fix) begin
            r_o_corr  <= r_corr_en;
            r_o_left  <= clamp_pwm(lsum);
            r_o_right <= clamp_pwm(rsum);
            r_o_dev   <= n_dev;
        end
    end

    assign o_correcting  = r_o_corr;
    assign o_left_speed  = r_o_left;
    assign o_right_speed = r_o_right;
    assign o_deviation   = r_o_dev;

endmodule

`default_nettype wire

### rtl/gydc_ctrl.sv
// controller: sequences one word through the datapath and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none

`include "gyro_yaw_differential_drive_correction_macros.svh"

module gydc_ctrl import gydc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        o_in_ready  = (r_state == S_IDLE) && i_rst_n;
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_QUOT;
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_FIX;
            end
            S_FIX: begin
                // wait until the result register is free
                if (out_free) begin
                    o_cmd.fix   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `GYDC_ASSERT_NXT(a_load_starts, i_clk, i_rst_n, o_cmd.load, r_state == S_MULT)
    `GYDC_ASSERT_NXT(a_fix_delivers, i_clk, i_rst_n, o_cmd.fix, r_out_valid && r_state == S_IDLE)
    `GYDC_ASSERT_IMP(a_valid_from_fix, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_FIX))
    `GYDC_ASSERT_NXT(a_accum_then_scale, i_clk, i_rst_n, r_state == S_ACCUM, r_state == S_SCALE)

endmodule

`default_nettype wire

### rtl/gyro_yaw_differential_drive_correction.sv
// top level of the gyro yaw differential drive correction block
`timescale 1ns / 1ps
`default_nettype none

// integrates raw gyro z rate times elapsed milliseconds into a saturating 40-bit yaw
// accumulator and steers a differential drive: left = base + correction, right =
// base - correction, each clamped to 0..255, with correction = deviation * gain / 65500
// truncated toward zero and clamped to the limit; it is zero in mode 0 and while
// |deviation| is below the threshold. mode 0 clears the heading reference. one word is
// in flight at a time: the next word is taken only once the controller is idle again.
// the controller takes each word through six steps (rate multiply, accumulate, gain
// multiply, reciprocal multiply, quotient correction, wheel clamp); the wheel clamp waits
// until the result register is free. config writes are registered. config writes belong to idle time.

module gyro_yaw_differential_drive_correction import gydc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    gydc_in_if.sink                    i_in,
    gydc_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    gydc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    gydc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    gydc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_mode        (i_in.mode),
        .i_gyro_z      (i_in.gyro_z),
        .i_elapsed_ms  (i_in.elapsed_ms),
        .i_robot_state (i_in.robot_state),
        .o_correcting  (o_out.correcting),
        .o_left_speed  (o_out.left_speed),
        .o_right_speed (o_out.right_speed),
        .o_deviation   (o_out.deviation)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire
